/* hdl/qdec_pkg.sv */
// ----------------------------------------------------------------------------
// qdec_pkg
// Types and constants shared by the quadrature decoder with acceleration.
// ----------------------------------------------------------------------------
`default_nettype none

package qdec_pkg;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_SLOPE    = 3'd1;
  localparam logic [2:0] REG_OFFSET   = 3'd2;
  localparam logic [2:0] REG_SHORT    = 3'd3;
  localparam logic [2:0] REG_LONG     = 3'd4;

  localparam int unsigned CFG_DATA_W = 24;

  // largest step after saturation
  localparam logic [15:0] STEP_MAX = 16'hFFFF;

  // input transaction
  typedef struct packed {
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         dir_now;
    logic               moved;
  } out_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic               debounce;
    logic signed [15:0] slope;
    logic signed [23:0] offset;
    logic [15:0]        short_cutoff;
    logic [15:0]        long_cutoff;
  } cfg_t;

  // edge stage result
  typedef struct packed {
    logic        valid;
    logic        moved;
    logic        cw;
    logic        accel;
    logic [1:0]  dir_now;
    logic [15:0] ivl;
  } edge_res_t;

  // step stage result
  typedef struct packed {
    logic        valid;
    logic        moved;
    logic        cw;
    logic [1:0]  dir_now;
    logic [15:0] step;
  } step_res_t;

endpackage

`default_nettype wire

/* hdl/quadrature_decoder_accel_unit.sv */
// Throughput: one transaction per cycle; the input register, edge stage,
// multiply stage, step stage and result register advance together and hold
// only while a finished result waits on out_ready.
// Reset (rst, synchronous): clears decoder state, position, all stage valids
// and the configuration registers.
// ----------------------------------------------------------------------------
// quadrature_decoder_accel_unit
// Quadrature decoder with direction debounce and speed-dependent step size.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_accel_unit import qdec_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      adv;
  logic      s0_valid;
  in_t       s0_data;
  edge_res_t edge_res;
  step_res_t step_res;

  // whole pipeline moves unless the result register is full and stalled
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg.debounce     <= cfg_data[0];
        REG_SLOPE:    cfg.slope        <= $signed(cfg_data[15:0]);
        REG_OFFSET:   cfg.offset       <= $signed(cfg_data[23:0]);
        REG_SHORT:    cfg.short_cutoff <= cfg_data[15:0];
        REG_LONG:     cfg.long_cutoff  <= cfg_data[15:0];
        default:      ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_data <= in_data;
    end
  end

  qdec_edge u_edge (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (s0_valid),
    .item       (s0_data),
    .cfg        (cfg),
    .res        (edge_res)
  );

  qdec_step u_step (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .edge_in (edge_res),
    .cfg     (cfg),
    .res     (step_res)
  );

  qdec_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .step_in   (step_res),
    .res_valid (out_valid),
    .res       (out_data)
  );

  // a step is only taken with an accepted direction
  a_moved_has_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.moved |-> out_data.dir_now != DIR_NONE)
    else $error("moved result without accepted direction");

  // position holds across a result that did not move
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) ##1 (out_valid && !out_data.moved)
      |-> out_data.position == $past(out_data.position))
    else $error("position changed without a step");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

/* hdl/qdec_edge.sv */
// ----------------------------------------------------------------------------
// qdec_edge
// Edge detection, direction debounce and edge interval for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_edge import qdec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire logic      item_valid,
  input  wire in_t       item,
  input  wire cfg_t      cfg,
  output edge_res_t      res
);

  // decoder state
  logic        primed;
  logic        last_a;
  logic [31:0] prev_edge_time;
  logic [1:0]  accepted_dir;
  logic [1:0]  candidate_dir;

  logic        primed_next;
  logic        last_a_next;
  logic [31:0] prev_edge_time_next;
  logic [1:0]  accepted_dir_next;
  logic [1:0]  candidate_dir_next;
  edge_res_t   res_next;

  logic [1:0]  new_dir;
  logic [31:0] interval;

  assign new_dir  = (item.pin_a != item.pin_b) ? DIR_CW : DIR_CCW;
  assign interval = item.now_ms - prev_edge_time;

  // next state and stage result
  always_comb begin
    primed_next         = primed;
    last_a_next         = last_a;
    prev_edge_time_next = prev_edge_time;
    accepted_dir_next   = accepted_dir;
    candidate_dir_next  = candidate_dir;
    res_next            = '0;
    res_next.valid      = item_valid;
    res_next.cw         = (new_dir == DIR_CW);
    res_next.accel      = (interval < {16'd0, cfg.long_cutoff}) && (cfg.slope != '0);
    res_next.ivl        = (interval < {16'd0, cfg.short_cutoff}) ? cfg.short_cutoff
                                                                 : interval[15:0];
    if (!primed) begin
      primed_next = 1'b1;
      last_a_next = item.pin_a;
    end else if (item.pin_a != last_a) begin
      if (cfg.debounce && (candidate_dir != new_dir)) begin
        candidate_dir_next = new_dir;
      end else begin
        accepted_dir_next = new_dir;
      end
      res_next.moved      = (accepted_dir_next == new_dir);
      last_a_next         = item.pin_a;
      prev_edge_time_next = item.now_ms;
    end
    res_next.dir_now = accepted_dir_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      primed         <= 1'b0;
      last_a         <= 1'b0;
      prev_edge_time <= '0;
      accepted_dir   <= DIR_NONE;
      candidate_dir  <= DIR_NONE;
      res            <= '0;
    end else if (adv) begin
      res <= res_next;
      if (item_valid) begin
        primed         <= primed_next;
        last_a         <= last_a_next;
        prev_edge_time <= prev_edge_time_next;
        accepted_dir   <= accepted_dir_next;
        candidate_dir  <= candidate_dir_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/qdec_step.sv */
// ----------------------------------------------------------------------------
// qdec_step
// Step size: slope times interval, plus offset, truncated and saturated; one when not accelerating.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_step import qdec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire edge_res_t edge_in,
  input  wire cfg_t      cfg,
  output step_res_t      res
);

  // product stage
  logic               p_valid;
  logic               p_moved;
  logic               p_cw;
  logic               p_accel;
  logic [1:0]         p_dir_now;
  logic signed [32:0] prod;

  logic signed [32:0] slope_ext;
  logic signed [32:0] ivl_ext;
  logic signed [33:0] q8;
  logic [15:0]        step_next;

  // multiplier operands at full product width
  assign slope_ext = 33'(cfg.slope);
  assign ivl_ext   = $signed({17'd0, edge_in.ivl});

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= edge_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_moved   <= edge_in.moved;
      p_cw      <= edge_in.cw;
      p_accel   <= edge_in.accel;
      p_dir_now <= edge_in.dir_now;
      prod      <= slope_ext * ivl_ext;
    end
  end

  // add offset, drop fraction, clamp to 0..65535
  assign q8 = 34'(prod) + 34'(cfg.offset);

  always_comb begin
    if (!p_accel) begin
      step_next = 16'd1;
    end else if (q8[33]) begin
      step_next = '0;
    end else if (|q8[32:24]) begin
      step_next = STEP_MAX;
    end else begin
      step_next = q8[23:8];
    end
  end

  // step stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (adv) begin
      res.valid   <= p_valid;
      res.moved   <= p_moved;
      res.cw      <= p_cw;
      res.dir_now <= p_dir_now;
      res.step    <= step_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/qdec_accum.sv */
// ----------------------------------------------------------------------------
// qdec_accum
// Position counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qdec_accum import qdec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire step_res_t step_in,
  output logic           res_valid,
  output out_t           res
);

  logic signed [31:0] pos_count;
  logic signed [31:0] pos_count_next;

  // clockwise counts down, counter-clockwise up, wrapping
  always_comb begin
    pos_count_next = pos_count;
    if (step_in.moved) begin
      if (step_in.cw) begin
        pos_count_next = pos_count - $signed({16'd0, step_in.step});
      end else begin
        pos_count_next = pos_count + $signed({16'd0, step_in.step});
      end
    end
  end

  // position and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= step_in.valid;
      if (step_in.valid) begin
        pos_count <= pos_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.position <= pos_count_next;
      res.dir_now  <= step_in.dir_now;
      res.moved    <= step_in.moved;
    end
  end

endmodule

`default_nettype wire
